// ===== sv/varint_length_record_deframer_macros.svh =====
// assertion macros shared by the deframer rtl
`ifndef VARINT_LENGTH_RECORD_DEFRAMER_MACROS_SVH
`define VARINT_LENGTH_RECORD_DEFRAMER_MACROS_SVH

// check a property on every clock edge outside reset
`define VLRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on every clock edge, reset included
`define VLRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/vlrd_pkg.sv =====
// shared types and constants of the varint length record deframer
package vlrd_pkg;

  // widths of the decoder state
  localparam int LEN_BITS   = 32;
  localparam int COUNT_BITS = 16;
  localparam int POS_BITS   = 32;
  localparam int SHIFT_BITS = 6;

  // varint group layout
  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [7:0] LAST_FLAG  = 8'h80;
  localparam int         GROUP_BITS = 7;

  // depth of the result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // end of buffer status codes
  typedef enum logic [2:0] {
    ST_CLEAN     = 3'd0,
    ST_TRUNC_HDR = 3'd1,
    ST_TRUNC_PAY = 3'd2,
    ST_LIMIT     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_buffer;
  } in_t;

  // one result item
  typedef struct packed {
    logic                  result_kind;
    logic [COUNT_BITS-1:0] record_index;
    logic [POS_BITS-1:0]   payload_offset;
    logic [LEN_BITS-1:0]   payload_length;
    logic [2:0]            end_status;
    logic [COUNT_BITS-1:0] records_found;
    logic                  last_result;
  } out_t;

endpackage

// ===== sv/varint_length_record_deframer.sv =====
// Varint length record deframer. Takes one buffer byte per item and one item per cycle
// while in_stall_o is low: an accepted item is held in the input register, then a single
// pass of logic updates the decoder state and writes zero, one or two results into a
// 4-entry result queue. Results leave at one per cycle while out_stall_i is low; an item
// that gives both a record descriptor and the end status fills two queue entries, so the
// sustained rate is one item per cycle unless the output side stalls or such items come
// in a row. Input stall rises while an item waits in the input register and the queue
// has fewer than two free entries. max_records is written through the config channel,
// which is always ready; it must only be written while the block is idle.
`include "varint_length_record_deframer_macros.svh"

module varint_length_record_deframer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vlrd_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vlrd_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vlrd_pkg::COUNT_BITS-1:0]   cfg_data_i
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_PAY
  } phase_e;

  localparam int LB = vlrd_pkg::LEN_BITS;
  localparam int CB = vlrd_pkg::COUNT_BITS;
  localparam int PB = vlrd_pkg::POS_BITS;
  localparam int SB = vlrd_pkg::SHIFT_BITS;
  localparam int GB = vlrd_pkg::GROUP_BITS;
  localparam int QD = vlrd_pkg::QUEUE_DEPTH;
  localparam int QP = vlrd_pkg::QPTR_BITS;
  localparam int QC = vlrd_pkg::QCNT_BITS;

  // config register
  logic [CB-1:0] max_q;

  // input register
  logic          in_vld_q;
  vlrd_pkg::in_t in_q;

  // decoder state
  phase_e            phase_q, phase_d;
  logic [LB-1:0]     acc_q, acc_d;
  logic [SB-1:0]     shift_q, shift_d;
  logic [LB-1:0]     rem_q, rem_d;
  logic [CB-1:0]     rec_q, rec_d;
  logic [PB-1:0]     pos_q, pos_d;
  logic [PB-1:0]     pstart_q, pstart_d;
  vlrd_pkg::status_e halt_q, halt_d;

  // result queue
  vlrd_pkg::out_t qmem_q [QD];
  logic [QP-1:0]  wr_q, rd_q;
  logic [QC-1:0]  cnt_q;

  logic           advance, pop;
  logic [1:0]     nres;
  vlrd_pkg::out_t res0, res1;

  // combinational scratch
  logic [LB+GB-1:0]  grp_shifted;
  logic [LB-1:0]     acc_new;
  logic              grp_ovf;
  logic              emit;
  logic [CB-1:0]     emit_idx;
  logic [PB-1:0]     emit_off;
  logic [LB-1:0]     emit_len;
  logic [SB:0]       next_shift;
  logic [PB-1:0]     pos_inc;
  vlrd_pkg::status_e st;
  vlrd_pkg::out_t    desc, stat;

  assign cfg_ready_o = 1'b1;

  // the stage moves on only when at least two queue entries are free
  assign advance    = in_vld_q && (cnt_q <= QC'(QD - 2));
  assign in_stall_o = in_vld_q && !advance;
  assign pop        = out_valid_o && !out_stall_i;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = qmem_q[rd_q];

  // varint group placed at the current shift
  assign grp_shifted = (LB+GB)'(in_q.data_byte & vlrd_pkg::GROUP_MASK) << shift_q;
  assign acc_new     = acc_q | grp_shifted[LB-1:0];
  assign grp_ovf     = |grp_shifted[LB+GB-1:LB];
  assign next_shift  = {1'b0, shift_q} + (SB+1)'(GB);
  assign pos_inc     = pos_q + PB'(1);

  // decoder update for the item in the input register
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    shift_d  = shift_q;
    rem_d    = rem_q;
    rec_d    = rec_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    halt_d   = halt_q;
    emit     = 1'b0;
    emit_idx = rec_q;
    emit_off = pstart_q;
    emit_len = acc_q;
    st       = vlrd_pkg::ST_CLEAN;

    if (in_q.has_byte && (halt_q == vlrd_pkg::ST_CLEAN)) begin
      if (phase_q == PH_PAY) begin
        rem_d = rem_q - LB'(1);
        if (rem_q == LB'(1)) begin
          emit = 1'b1;
        end
      end else if ((phase_q == PH_IDLE) && (rec_q >= max_q)) begin
        halt_d = vlrd_pkg::ST_LIMIT;
      end else begin
        phase_d = PH_HEAD;
        if (grp_ovf) begin
          halt_d = vlrd_pkg::ST_OVERFLOW;
        end else begin
          acc_d = acc_new;
          if ((in_q.data_byte & vlrd_pkg::LAST_FLAG) != '0) begin
            pstart_d = pos_inc;
            if (acc_new == '0) begin
              emit     = 1'b1;
              emit_off = pos_inc;
              emit_len = '0;
            end else begin
              phase_d = PH_PAY;
              rem_d   = acc_new;
            end
          end else if (next_shift >= (SB+1)'(LB)) begin
            halt_d = vlrd_pkg::ST_OVERFLOW;
          end else begin
            shift_d = next_shift[SB-1:0];
          end
        end
      end
    end

    // record done: back to header idle
    if (emit) begin
      rec_d   = rec_q + CB'(1);
      phase_d = PH_IDLE;
      acc_d   = '0;
      shift_d = '0;
      rem_d   = '0;
    end

    if (in_q.has_byte) begin
      pos_d = pos_inc;
    end

    // end status from the updated state
    if (halt_d != vlrd_pkg::ST_CLEAN) begin
      st = halt_d;
    end else if (phase_d == PH_HEAD) begin
      st = vlrd_pkg::ST_TRUNC_HDR;
    end else if (phase_d == PH_PAY) begin
      st = vlrd_pkg::ST_TRUNC_PAY;
    end

    desc = '{result_kind: vlrd_pkg::KIND_RECORD, record_index: emit_idx,
             payload_offset: emit_off, payload_length: emit_len,
             end_status: vlrd_pkg::ST_CLEAN, records_found: '0,
             last_result: !in_q.end_of_buffer};
    stat = '{result_kind: vlrd_pkg::KIND_STATUS, record_index: '0,
             payload_offset: '0, payload_length: '0, end_status: st,
             records_found: rec_d, last_result: 1'b1};

    // buffer end: clear for the next buffer
    if (in_q.end_of_buffer) begin
      phase_d  = PH_IDLE;
      acc_d    = '0;
      shift_d  = '0;
      rem_d    = '0;
      rec_d    = '0;
      pos_d    = '0;
      pstart_d = '0;
      halt_d   = vlrd_pkg::ST_CLEAN;
    end

    // pack the results in order
    nres = 2'(emit) + 2'(in_q.end_of_buffer);
    res0 = emit ? desc : stat;
    res1 = stat;
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      shift_q  <= '0;
      rem_q    <= '0;
      rec_q    <= '0;
      pos_q    <= '0;
      pstart_q <= '0;
      halt_q   <= vlrd_pkg::ST_CLEAN;
    end else if (advance) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      rem_q    <= rem_d;
      rec_q    <= rec_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      halt_q   <= halt_d;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (advance) begin
        wr_q <= wr_q + QP'(nres);
      end
      if (pop) begin
        rd_q <= rd_q + QP'(1);
      end
      cnt_q <= cnt_q + (advance ? QC'(nres) : QC'(0)) - QC'(pop);
    end
  end

  // result queue entries
  always_ff @(posedge clk_i) begin
    if (advance && (nres != 2'd0)) begin
      qmem_q[wr_q] <= res0;
    end
    if (advance && (nres == 2'd2)) begin
      qmem_q[wr_q + QP'(1)] <= res1;
    end
  end

  `VLRD_ASSERT(a_queue_bound, cnt_q <= QC'(QD), "result queue over its depth")
  `VLRD_ASSERT(a_pay_nonzero, (phase_q == PH_PAY) |-> (rem_q != '0), "payload phase with nothing left")
  `VLRD_ASSERT(a_idle_clear, (phase_q == PH_IDLE) |-> (acc_q == '0 && shift_q == '0), "idle header with stale length")
  `VLRD_ASSERT(a_eob_clears, (advance && in_q.end_of_buffer) |=> (rec_q == '0 && halt_q == vlrd_pkg::ST_CLEAN && pos_q == '0), "state not cleared at buffer end")
  `VLRD_ASSERT(a_shift_range, shift_q < SB'(LB), "group shift beyond length width")

endmodule
